// ===== rtl/core/fpts_pkg.sv =====
// Shared types, constants and operation codes of the fixed priority task scheduler.
// No dependencies; imported by fpts_sub and fixed_priority_task_scheduler_top.
package fpts_pkg;

   // Task slots: slot 0 is the main loop, slots 1..MAX_TASKS are created tasks
   localparam int MAX_TASKS = 7;
   localparam int SLOT_W    = 3;
   localparam int NSLOTS    = MAX_TASKS + 1;
   localparam int ADDR_W    = 16;
   localparam int FRAME_W   = 8;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // Operation codes
   typedef logic [2:0] op_type;
   localparam op_type OP_INIT     = 3'd0;
   localparam op_type OP_CREATE   = 3'd1;
   localparam op_type OP_IDLE     = 3'd2;
   localparam op_type OP_SET_RUN  = 3'd3;
   localparam op_type OP_SCHEDULE = 3'd4;

   // Configuration register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_STACK_BASE  = 2'd0;
   localparam csr_idx_type CSR_STACK_FLOOR = 2'd1;
   localparam csr_idx_type CSR_FRAME_SIZE  = 2'd2;

   // Reset values
   localparam addr_type            STACK_BASE_RST  = 16'd2047;
   localparam addr_type            STACK_FLOOR_RST = 16'd1024;
   localparam logic [FRAME_W-1:0]  FRAME_SIZE_RST  = 8'd9;

   // Result of the shared subtractor
   typedef struct packed {
      addr_type diff;
      logic     borrow;
      logic     zero;
   } sub_res_type;

endpackage

// ===== rtl/core/fpts_sub.sv =====
// Shared 16-bit subtract unit with borrow and zero flags.
// Depends on fpts_pkg.
module fpts_sub
   import fpts_pkg::*;
(
   input  addr_type    a,
   input  addr_type    b,
   output sub_res_type res
);

   logic [ADDR_W:0] wide;

   // a - b with one extra bit for the borrow
   assign wide       = {1'b0, a} - {1'b0, b};
   assign res.diff   = wide[ADDR_W-1:0];
   assign res.borrow = wide[ADDR_W];
   assign res.zero   = (wide[ADDR_W-1:0] == '0);

endmodule

// ===== rtl/core/fixed_priority_task_scheduler_top.sv =====
// Top level of the fixed priority task scheduler: sequencer, task state, result register.
// Depends on fpts_pkg and fpts_sub.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | op, mem_size, task_index, current_context
//  rsp     | out       | rsp_valid/rsp_stall | created_index, switched, next_task,
//          |           |                     | load_context, run_mask
//  csr     | in        | csr_write           | csr_index, csr_data
//
// One request at a time: init, idle and set run go from the execute state straight to done;
// create makes five passes through the one shared subtractor and ends early when no slot
// is left or when a short stack has no room left above the floor; schedule scans, then switches
// (the priority scan tests one slot per cycle, from the highest created slot down).
// Reset is synchronous and active high; no clearing pass is needed.
// A finished result waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and holds in its last cycle until the register frees.
module fixed_priority_task_scheduler_top
   import fpts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [15:0]         req_mem_size,
   input  logic [2:0]          req_task_index,
   input  logic [15:0]         req_current_context,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_created_index,
   output logic                rsp_switched,
   output logic [2:0]          rsp_next_task,
   output logic [15:0]         rsp_load_context,
   output logic [7:0]          rsp_run_mask,
   // configuration port
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EXEC    = 4'd1;
   localparam logic [3:0] ST_C_DIFF  = 4'd2;
   localparam logic [3:0] ST_C_FLOOR = 4'd3;
   localparam logic [3:0] ST_C_ROOM  = 4'd4;
   localparam logic [3:0] ST_C_CTX   = 4'd5;
   localparam logic [3:0] ST_C_OFFS  = 4'd6;
   localparam logic [3:0] ST_SCAN    = 4'd7;
   localparam logic [3:0] ST_SWITCH  = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   logic [3:0]          state_ff, state_in;

   // Configuration
   addr_type            stack_base_ff, stack_floor_ff;
   logic [FRAME_W-1:0]  frame_size_ff;

   // Task state
   logic [NSLOTS-1:0]   running_ff, running_in;
   addr_type            context_ff [NSLOTS];
   addr_type            offset_ff, offset_in;
   slot_type            count_ff, count_in;
   slot_type            current_ff, current_in;

   // Latched request
   op_type              op_ff;
   addr_type            mem_ff;
   slot_type            tix_ff;
   addr_type            ctx_ff;

   // Work registers
   slot_type            pick_ff, pick_in;
   addr_type            diff_ff, diff_in;
   logic                neg_ff, neg_in;
   logic                short_ff, short_in;
   addr_type            req_ff, req_in;
   slot_type            res_created_ff, res_created_in;
   logic                res_switch_ff, res_switch_in;
   addr_type            res_load_ff, res_load_in;

   // Context write port
   logic                ctx_we;
   slot_type            ctx_waddr;
   addr_type            ctx_wdata;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_load;
   logic                out_free;

   // Shared subtractor
   addr_type            sub_a, sub_b;
   sub_res_type         sub_res;
   slot_type            new_slot;
   logic                req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign new_slot  = count_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the shared subtractor
   always_comb begin
      sub_a = offset_ff;
      sub_b = stack_floor_ff;
      case (state_ff)
         ST_C_DIFF:  sub_b = mem_ff;
         ST_C_FLOOR: begin
            sub_a = diff_ff;
            sub_b = stack_floor_ff;
         end
         ST_C_ROOM:  sub_b = stack_floor_ff;
         ST_C_CTX:   sub_b = {{(ADDR_W-FRAME_W){1'b0}}, frame_size_ff};
         ST_C_OFFS:  sub_b = req_ff;
         default:    sub_b = stack_floor_ff;
      endcase
   end

   fpts_sub u_sub (
      .a   (sub_a),
      .b   (sub_b),
      .res (sub_res)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      running_in     = running_ff;
      offset_in      = offset_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      pick_in        = pick_ff;
      diff_in        = diff_ff;
      neg_in         = neg_ff;
      short_in       = short_ff;
      req_in         = req_ff;
      res_created_in = res_created_ff;
      res_switch_in  = res_switch_ff;
      res_load_in    = res_load_ff;
      ctx_we         = 1'b0;
      ctx_waddr      = current_ff;
      ctx_wdata      = ctx_ff;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_created_in = '0;
            res_switch_in  = 1'b0;
            res_load_in    = '0;
            pick_in        = count_ff;
            state_in       = ST_DONE;
            case (op_ff)
               OP_INIT: begin
                  offset_in     = stack_base_ff;
                  count_in      = '0;
                  current_in    = '0;
                  running_in[0] = 1'b1;
               end
               OP_CREATE:   state_in = ST_C_DIFF;
               OP_IDLE:     running_in[current_ff] = 1'b0;
               OP_SET_RUN: begin
                  if (32'(tix_ff) <= MAX_TASKS) begin
                     running_in[tix_ff] = 1'b1;
                  end
               end
               OP_SCHEDULE: state_in = ST_SCAN;
               default:     state_in = ST_DONE;
            endcase
         end
         // offset - mem; a borrow means the request overruns address zero
         ST_C_DIFF: begin
            diff_in  = sub_res.diff;
            neg_in   = sub_res.borrow;
            state_in = (32'(count_ff) == MAX_TASKS) ? ST_DONE : ST_C_FLOOR;
         end
         // short of stack when below the floor
         ST_C_FLOOR: begin
            short_in = neg_ff || sub_res.borrow;
            state_in = ST_C_ROOM;
         end
         // when short, cut the request to the room left above the floor; no room ends the create
         ST_C_ROOM: begin
            req_in   = mem_ff;
            state_in = ST_C_CTX;
            if (short_ff) begin
               req_in = sub_res.diff;
               if (sub_res.borrow || sub_res.zero) begin
                  state_in = ST_DONE;
               end
            end
         end
         // initial context of the new slot
         ST_C_CTX: begin
            ctx_we               = 1'b1;
            ctx_waddr            = new_slot;
            ctx_wdata            = sub_res.diff;
            running_in[new_slot] = 1'b0;
            count_in             = new_slot;
            state_in             = ST_C_OFFS;
         end
         ST_C_OFFS: begin
            offset_in      = sub_res.diff;
            res_created_in = count_ff;
            state_in       = ST_DONE;
         end
         // one slot a cycle, highest priority first
         ST_SCAN: begin
            if (pick_ff == '0 || running_ff[pick_ff]) begin
               state_in = ST_SWITCH;
            end else begin
               pick_in = pick_ff - 1'b1;
            end
         end
         ST_SWITCH: begin
            if (pick_ff != current_ff) begin
               ctx_we        = 1'b1;
               ctx_waddr     = current_ff;
               ctx_wdata     = ctx_ff;
               res_load_in   = context_ff[pick_ff];
               res_switch_in = 1'b1;
               current_in    = pick_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and task state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         running_ff     <= NSLOTS'(1);
         offset_ff      <= STACK_BASE_RST;
         count_ff       <= '0;
         current_ff     <= '0;
         stack_base_ff  <= STACK_BASE_RST;
         stack_floor_ff <= STACK_FLOOR_RST;
         frame_size_ff  <= FRAME_SIZE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         offset_ff    <= offset_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         if (csr_write) begin
            case (csr_index)
               CSR_STACK_BASE:  stack_base_ff  <= csr_data;
               CSR_STACK_FLOOR: stack_floor_ff <= csr_data;
               CSR_FRAME_SIZE:  frame_size_ff  <= csr_data[FRAME_W-1:0];
               default:         ;
            endcase
         end
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_op;
         mem_ff <= req_mem_size;
         tix_ff <= req_task_index;
         ctx_ff <= req_current_context;
      end
      pick_ff        <= pick_in;
      diff_ff        <= diff_in;
      neg_ff         <= neg_in;
      short_ff       <= short_in;
      req_ff         <= req_in;
      res_created_ff <= res_created_in;
      res_switch_ff  <= res_switch_in;
      res_load_ff    <= res_load_in;
      if (ctx_we) begin
         context_ff[ctx_waddr] <= ctx_wdata;
      end
      if (out_load) begin
         rsp_created_index <= res_created_ff;
         rsp_switched      <= res_switch_ff;
         rsp_next_task     <= current_ff;
         rsp_load_context  <= res_load_ff;
         rsp_run_mask      <= running_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // Created slot count never passes the number of task slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_TASKS)
      else $error("created slot count out of range");

   // The scan never looks above the highest created slot
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (pick_ff <= count_ff))
      else $error("scan pointer above created slots");

   // A switch result never also reports a created slot
   a_switch_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switched) |-> (rsp_created_index == '0))
      else $error("switch and create in one result");

   // A created slot starts idle
   a_new_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_CTX) |=> !running_ff[count_ff])
      else $error("new slot not idle");
`endif

endmodule
